// ===== hw/rtl/dpv_pkg.sv =====
// Shared types and constants for the delta prefix varint encoder.
package dpv_pkg;

    localparam int ValueWidth = 32;
    localparam int NumClasses = 8;
    localparam int PartWidth  = 7;
    localparam int AccWidth   = 47;
    localparam int WordBytes  = 6;
    localparam int WordWidth  = 8 * WordBytes;
    localparam int TermBytes  = 5;

    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam logic [7:0] FILL_BYTE = 8'hFF;

    // Lower bound of each difference class, smallest class first.
    localparam logic [ValueWidth-1:0] CLASS_BASE [NumClasses] = '{
        32'h0000_0000, 32'h0000_0010, 32'h0000_0110, 32'h0000_1110,
        32'h0001_1110, 32'h0011_1110, 32'h0111_1110, 32'h1111_1110
    };

    typedef struct packed {
        logic                         action;
        logic signed [ValueWidth-1:0] value;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_in_run;
        logic       stream_end;
    } out_t;

    // Completed bytes of one item, left-aligned, with their count.
    typedef struct packed {
        logic [WordWidth-1:0] data;
        logic [2:0]           nb;
        logic                 stream_end;
    } word_t;

endpackage

// ===== hw/rtl/delta_prefix_varint_encoder.sv =====
// Top level of the delta prefix varint encoder: input register, coder, byte sender.
//
//  channel   dir  handshake              payload
//  in        in   in_valid / in_ready    in_data  (action, value)
//  out       out  out_valid / out_ready  out_data (out_byte, last_in_run, stream_end)
//
// An item is coded combinationally from the input register into the byte sender.
// The sender emits one byte per cycle while out_ready is high: up to 5 bytes
// for an encode, 5 or 6 for a finish; an encode with no whole byte loads nothing.
// Reset clears the stream state and both valid flags; no clearing pass.
// A stall on out holds the byte; the input register holds one item meanwhile.
module delta_prefix_varint_encoder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dpv_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output dpv_pkg::out_t  out_data
);
    import dpv_pkg::*;

    in_t   item_reg;
    logic  item_valid_reg, item_valid_next;
    word_t word;
    logic  ser_free;
    logic  go;
    logic  load;

    assign go       = item_valid_reg && ser_free;
    assign load     = go && word.nb != 3'd0;
    assign in_ready = !item_valid_reg || go;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_ready)
        begin
            item_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    dpv_encode u_encode (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .item  (item_reg),
        .word  (word)
    );

    dpv_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .word      (word),
        .free      (ser_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== hw/rtl/dpv_encode.sv =====
// Delta, class coding and bit packing of one item, plus the stream state.
module dpv_encode (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           go,
    input  dpv_pkg::in_t   item,
    output dpv_pkg::word_t word
);
    import dpv_pkg::*;

    logic [ValueWidth-1:0] prev_reg, prev_next;
    logic [PartWidth-1:0]  part_reg, part_next;
    logic [2:0]            cnt_reg, cnt_next;

    logic [ValueWidth-1:0] diff;
    logic [2:0]            kidx;
    logic [3:0]            k;
    logic [ValueWidth-1:0] payload;
    logic [7:0]            prefix;
    logic [5:0]            len;
    logic [39:0]           code;
    logic [AccWidth-1:0]   acc;
    logic [5:0]            total;
    logic [5:0]            sh;
    logic [WordWidth-1:0]  aligned;
    logic [7:0]            flush_byte;

    always_comb
    begin
        diff = ValueWidth'(item.value) - prev_reg;
        // Bases rise, so the class index is the last base not above diff.
        kidx = 3'd0;
        for (int j = 1; j < NumClasses; j++)
        begin
            if (diff >= CLASS_BASE[j])
            begin
                kidx = 3'(j);
            end
        end
        k       = {1'b0, kidx} + 4'd1;
        payload = diff - CLASS_BASE[kidx];
        prefix  = 8'((9'd1 << kidx) - 9'd1) << 1;
        len     = 6'(k) * 6'd5;
        code    = (40'(prefix) << {k, 2'b00}) | 40'(payload);
        acc     = (AccWidth'(part_reg) << len) | AccWidth'(code);
        total   = 6'(cnt_reg) + len;
        sh      = 6'(WordWidth) - total;
        aligned = WordWidth'(acc) << sh;

        flush_byte = 8'(16'(part_reg) << (4'd8 - {1'b0, cnt_reg})) | (FILL_BYTE >> cnt_reg);
    end

    always_comb
    begin
        prev_next = prev_reg;
        part_next = part_reg;
        cnt_next  = cnt_reg;
        if (item.action == ACT_FINISH)
        begin
            word.stream_end = 1'b1;
            if (cnt_reg != 3'd0)
            begin
                word.data = {flush_byte, {(8 * TermBytes){1'b1}}};
                word.nb   = 3'(TermBytes + 1);
            end
            else
            begin
                word.data = {{(8 * TermBytes){1'b1}}, 8'h00};
                word.nb   = 3'(TermBytes);
            end
            if (go)
            begin
                prev_next = '0;
                part_next = '0;
                cnt_next  = '0;
            end
        end
        else
        begin
            word.stream_end = 1'b0;
            word.data       = aligned;
            word.nb         = total[5:3];
            if (go)
            begin
                prev_next = ValueWidth'(item.value);
                part_next = acc[PartWidth-1:0] & PartWidth'((8'd1 << total[2:0]) - 8'd1);
                cnt_next  = total[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            part_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            prev_reg <= prev_next;
            part_reg <= part_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/dpv_serializer.sv =====
// Result register that sends the completed bytes of one item, one per cycle while out_ready is high.
module dpv_serializer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  dpv_pkg::word_t word,
    output logic           free,
    output logic           out_valid,
    input  logic           out_ready,
    output dpv_pkg::out_t  out_data
);
    import dpv_pkg::*;

    logic [WordWidth-1:0] data_reg, data_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic                 end_reg, end_next;
    logic                 take;

    assign out_valid            = cnt_reg != 3'd0;
    assign take                 = out_valid && out_ready;
    assign free                 = !out_valid || (out_ready && cnt_reg == 3'd1);
    assign out_data.out_byte    = data_reg[WordWidth-1 -: 8];
    assign out_data.last_in_run = cnt_reg == 3'd1;
    assign out_data.stream_end  = end_reg;

    always_comb
    begin
        data_next = data_reg;
        cnt_next  = cnt_reg;
        end_next  = end_reg;
        if (load)
        begin
            data_next = word.data;
            cnt_next  = word.nb;
            end_next  = word.stream_end;
        end
        else if (take)
        begin
            data_next = data_reg << 8;
            cnt_next  = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        end_reg  <= end_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(WordBytes))
        else $error("byte count out of range");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("word loaded over unsent bytes");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !load && cnt_reg > 3'd1) |=> cnt_reg == $past(cnt_reg) - 3'd1)
        else $error("byte count did not step down");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(cnt_reg) && $stable(data_reg)))
        else $error("stalled byte changed");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the delta prefix varint encoder: byte-exact prediction and checking.
module tb_top;
    import dpv_pkg::*;

    localparam int NumRandom  = 430;
    localparam int CalmItems  = 60;
    localparam int HoldAt     = 150;
    localparam int HoldItems  = 30;
    localparam int HoldCycles = 300;
    localparam int DrainWait  = 20;
    localparam int CycleLimit = 200000;
    localparam int MaxPrinted = 40;

    // Predicts the coded byte stream and checks the block's bytes against it.
    class stream_checker;
        out_t        expected_bytes[$];
        logic [31:0] prev_value;
        logic [6:0]  part_bits;
        int          part_count;
        int          errors;

        function new();
            errors = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            prev_value = '0;
            part_bits  = '0;
            part_count = 0;
        endfunction

        function void queue_byte(logic [7:0] b, logic last, logic fin);
            out_t r;
            r.out_byte    = b;
            r.last_in_run = last;
            r.stream_end  = fin;
            expected_bytes.push_back(r);
        endfunction

        function void encode_delta(logic [31:0] val);
            logic [31:0] diff;
            logic [63:0] word;
            int          cls;
            int          nbits;
            int          avail;
            diff       = val - prev_value;
            prev_value = val;
            cls = 1;
            while (cls < NumClasses && diff >= CLASS_BASE[cls])
                cls++;
            nbits = 5 * cls;
            // prefix: cls-1 ones then a zero, above the 4*cls payload bits
            word  = ((64'd1 << (cls - 1)) - 64'd1) << 1;
            word  = (word << (4 * cls)) | 64'(diff - CLASS_BASE[cls - 1]);
            word  = (64'(part_bits) << nbits) | word;
            avail = part_count + nbits;
            while (avail >= 8)
            begin
                avail -= 8;
                queue_byte(8'(word >> avail), avail < 8, 1'b0);
            end
            part_count = avail;
            part_bits  = 7'(word & ((64'd1 << avail) - 64'd1));
        endfunction

        function void close_stream();
            logic [7:0] pad;
            if (part_count != 0)
            begin
                // fill the open byte with ones
                pad = (8'(part_bits) << (8 - part_count)) | (8'hFF >> part_count);
                queue_byte(pad, 1'b0, 1'b1);
            end
            for (int i = 0; i < TermBytes; i++)
                queue_byte(FILL_BYTE, i == TermBytes - 1, 1'b1);
            clear_stream();
        endfunction

        function void note_input(in_t it);
            if (it.action == ACT_FINISH)
                close_stream();
            else
                encode_delta(it.value);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MaxPrinted)
                $display("ERROR: %s", msg);
        endtask

        task check_result(out_t got);
            out_t want;
            if (expected_bytes.size() == 0)
            begin
                report($sformatf("unexpected byte %02h last=%0b end=%0b",
                                 got.out_byte, got.last_in_run, got.stream_end));
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
            if (got.last_in_run !== want.last_in_run)
                report($sformatf("last_in_run %0b, want %0b on byte %02h",
                                 got.last_in_run, want.last_in_run, want.out_byte));
            if (got.stream_end !== want.stream_end)
                report($sformatf("stream_end %0b, want %0b on byte %02h",
                                 got.stream_end, want.stream_end, want.out_byte));
        endtask

        task check_drained();
            if (expected_bytes.size() != 0)
                report($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
        endtask
    endclass

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    in_t   in_data   = '0;
    logic  out_ready = 1'b0;
    logic  in_ready;
    logic  out_valid;
    out_t  out_data;

    stream_checker coder_model = new();

    logic [31:0] stream_last = '0;
    bit          calm        = 1'b0;
    bit          hold_req    = 1'b0;
    bit          hold_done   = 1'b0;
    int          hold_left   = 0;
    int          stall_left  = 0;
    int          cycle_count = 0;

    delta_prefix_varint_encoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: check each accepted byte, then pick next cycle's ready.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            coder_model.check_result(out_data);
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_item(input in_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        coder_model.note_input(it);
    endtask

    task automatic pause_sender(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_encode(input logic [31:0] v);
        in_t it;
        it.action = ACT_ENCODE;
        it.value  = v;
        send_item(it);
        stream_last = v;
    endtask

    task automatic send_delta(input logic [31:0] d);
        send_encode(stream_last + d);
    endtask

    task automatic send_finish();
        in_t it;
        it.action = ACT_FINISH;
        it.value  = $urandom;
        send_item(it);
        stream_last = '0;
    endtask

    // Pick a difference from a random class, leaning on its edges.
    function automatic logic [31:0] pick_delta();
        int          cls;
        logic [31:0] lo;
        logic [31:0] hi;
        cls = $urandom_range(1, NumClasses);
        lo  = CLASS_BASE[cls - 1];
        hi  = (cls == NumClasses) ? 32'hFFFF_FFFF : CLASS_BASE[cls] - 32'd1;
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    initial
    begin
        static logic [31:0] edge_deltas [12] = '{
            32'h0000_000F, 32'h0000_0010, 32'h0000_010F, 32'h0000_0110,
            32'h0000_110F, 32'h0000_1110, 32'h0001_110F, 32'h0001_1110,
            32'h0011_1110, 32'h0111_110F, 32'h0111_1110, 32'hFFFF_FFFF
        };
        int roll;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty streams, partial and whole bytes, class edges, value extremes
        send_finish();
        send_encode(32'h0);
        send_finish();
        send_delta(32'h1111_1110);
        send_finish();
        foreach (edge_deltas[i])
            send_delta(edge_deltas[i]);
        send_encode(32'h7FFF_FFFF);
        send_encode(32'h8000_0000);
        send_encode(32'hFFFF_FFFF);
        send_encode(32'h0);
        send_finish();

        for (int i = 0; i < NumRandom; i++)
        begin
            if (i == HoldAt)
                hold_req = 1'b1;
            calm = (i >= NumRandom - CalmItems);
            if (!calm && !(i >= HoldAt && i < HoldAt + HoldItems)
                && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 9));
            roll = $urandom_range(0, 99);
            if (roll < 7)
                send_finish();
            else if (roll < 17)
                send_encode($urandom);
            else
                send_delta(pick_delta());
        end
        in_valid <= 1'b0;

        while (coder_model.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
        coder_model.check_drained();
        if (coder_model.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== delta_prefix_varint_encoder.f =====
hw/rtl/dpv_pkg.sv
hw/rtl/dpv_encode.sv
hw/rtl/dpv_serializer.sv
hw/rtl/delta_prefix_varint_encoder.sv
tb/tb_top.sv
